// ----- sv/hce_pkg.sv -----
// shared codes, state types and the code table write bundle for the huffman encoder
// no dependencies
package hce_pkg;

  localparam logic [2:0] CMD_COUNT  = 3'd0;
  localparam logic [2:0] CMD_BUILD  = 3'd1;
  localparam logic [2:0] CMD_ENCODE = 3'd2;
  localparam logic [2:0] CMD_FLUSH  = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  localparam logic [1:0] KIND_PACKED = 2'd0;
  localparam logic [1:0] KIND_BUILT  = 2'd1;
  localparam logic [1:0] KIND_FINAL  = 2'd2;
  localparam logic [1:0] KIND_EMPTY  = 2'd3;

  localparam logic [2:0] MAX_RESULTS = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE, S_COUNT, S_BUILD, S_REPORT, S_FLUSH, S_ENC_LOAD, S_ENC_SHIFT
  } top_state_t;

  typedef enum logic [3:0] {
    T_IDLE, T_COLLECT, T_SCAN, T_LINK_A, T_LINK_B, T_LINK_J,
    T_WALK_A, T_WALK_B, T_WALK_C, T_DONE
  } tree_state_t;

  typedef struct packed {
    logic        en;
    logic [7:0]  sym;
    logic [6:0]  len;
    logic [63:0] bits;
  } code_wr_t;

endpackage

// ----- sv/hce_if.sv -----
// valid/ready channels of the huffman encoder: command beats in, result beats out
// no dependencies
interface hce_item_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] data_byte;
  modport source (output valid, command, data_byte, input ready);
  modport sink   (input valid, command, data_byte, output ready);
endinterface

interface hce_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [2:0] pad_bits;
  logic [8:0] symbol_count;
  logic       last;
  modport source (output valid, kind, out_byte, pad_bits, symbol_count, last, input ready);
  modport sink   (input valid, kind, out_byte, pad_bits, symbol_count, last, output ready);
endinterface

// ----- sv/hce_hist.sv -----
// symbol histogram memory, one read and one write port, per-entry valid bits
// depends on nothing outside this file
module hce_hist #(
  parameter int SYMBOLS     = 256,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clr,
  input  logic [$clog2(SYMBOLS)-1:0] rd_addr,
  output logic [COUNT_WIDTH-1:0]     rd_data,
  input  logic                       wr_en,
  input  logic [$clog2(SYMBOLS)-1:0] wr_addr,
  input  logic [COUNT_WIDTH-1:0]     wr_data
);
  logic [COUNT_WIDTH-1:0] mem [SYMBOLS];
  logic [SYMBOLS-1:0]     vld;
  logic [COUNT_WIDTH-1:0] rd_q;
  logic                   rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // an entry never written since clear reads as zero
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      rd_vld <= vld[rd_addr];
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;
endmodule

// ----- sv/hce_tree.sv -----
// tree builder: collects leaves, merges the two lightest free nodes by a
// repeated scan, then walks down from the root writing codes; uses hce_pkg
module hce_tree #(
  parameter int SYMBOLS       = 256,
  parameter int COUNT_WIDTH   = 32,
  parameter int MAX_CODE_BITS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic [$clog2(SYMBOLS)-1:0]       hist_addr,
  input  logic [COUNT_WIDTH-1:0]           hist_data,
  output hce_pkg::code_wr_t                code_wr,
  output logic                             done,
  output logic [$clog2(SYMBOLS+1)-1:0]     count
);
  localparam int SYM_W  = $clog2(SYMBOLS);
  localparam int CNT_W  = $clog2(SYMBOLS + 1);
  localparam int NODES  = 2 * SYMBOLS - 1;
  localparam int NODE_W = $clog2(NODES);
  localparam int LEN_W  = $clog2(MAX_CODE_BITS + 1);
  localparam int NW     = 1 + NODE_W + COUNT_WIDTH;
  localparam int CDW    = LEN_W + MAX_CODE_BITS;

  hce_pkg::tree_state_t state, state_next;

  logic [CNT_W-1:0]       s, s_next;
  logic [NODE_W-1:0]      n, n_next, j, j_next, i, i_next;
  logic [NODE_W-1:0]      bidx, bidx_next, sidx, sidx_next;
  logic [COUNT_WIDTH-1:0] bw, bw_next, sw, sw_next;
  logic                   bf, bf_next, sf, sf_next;

  logic [NW-1:0]     node_mem [NODES];
  logic [NODE_W-1:0] left_mem [NODES];
  logic [SYM_W-1:0]  leaf_mem [SYMBOLS];
  logic [CDW-1:0]    code_mem [NODES];

  logic [NW-1:0]     node_q;
  logic [NODE_W-1:0] left_q;
  logic [SYM_W-1:0]  leaf_q;
  logic [CDW-1:0]    code_q;

  logic              node_we, left_we, leaf_we, code_we;
  logic [NODE_W-1:0] node_waddr, code_waddr;
  logic [NW-1:0]     node_wdata;
  logic [CDW-1:0]    code_wdata;

  logic                   nq_hp;
  logic [NODE_W-1:0]      nq_par;
  logic [COUNT_WIDTH-1:0] nq_w;
  logic [NODE_W-1:0]      i_m1, root;
  logic [LEN_W-1:0]       pl, nl;
  logic [MAX_CODE_BITS-1:0] pc, nc;
  logic                   bit_v;

  assign nq_hp  = node_q[NW-1];
  assign nq_par = node_q[COUNT_WIDTH +: NODE_W];
  assign nq_w   = node_q[COUNT_WIDTH-1:0];
  assign i_m1   = i - NODE_W'(1);
  assign root   = (n << 1) - NODE_W'(2);
  assign pl     = code_q[CDW-1 -: LEN_W];
  assign pc     = code_q[MAX_CODE_BITS-1:0];
  assign bit_v  = (left_q != i);
  assign hist_addr = s[SYM_W-1:0];
  assign count  = CNT_W'(n);

  // depth is capped: past the limit a node inherits its parent's code
  always_comb begin
    if (pl < LEN_W'(MAX_CODE_BITS)) begin
      nc = {pc[MAX_CODE_BITS-2:0], bit_v};
      nl = pl + LEN_W'(1);
    end else begin
      nc = pc;
      nl = pl;
    end
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    if (left_we) begin
      left_mem[j] <= bidx;
    end
    if (leaf_we) begin
      leaf_mem[n[SYM_W-1:0]] <= SYM_W'(s - CNT_W'(1));
    end
    if (code_we) begin
      code_mem[code_waddr] <= code_wdata;
    end
    node_q <= node_mem[i];
    left_q <= left_mem[nq_par];
    code_q <= code_mem[nq_par];
    leaf_q <= leaf_mem[i[SYM_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hce_pkg::T_IDLE;
    end else begin
      state <= state_next;
    end
    s <= s_next;
    n <= n_next;
    j <= j_next;
    i <= i_next;
    bidx <= bidx_next;
    sidx <= sidx_next;
    bw <= bw_next;
    sw <= sw_next;
    bf <= bf_next;
    sf <= sf_next;
  end

  always_comb begin
    state_next = state;
    s_next = s;
    n_next = n;
    j_next = j;
    i_next = i;
    bidx_next = bidx;
    sidx_next = sidx;
    bw_next = bw;
    sw_next = sw;
    bf_next = bf;
    sf_next = sf;
    node_we = 1'b0;
    node_waddr = n;
    node_wdata = '0;
    left_we = 1'b0;
    leaf_we = 1'b0;
    code_we = 1'b0;
    code_waddr = i;
    code_wdata = '0;
    code_wr = '0;
    done = 1'b0;
    case (state)
      hce_pkg::T_IDLE: begin
        if (start) begin
          s_next = '0;
          n_next = '0;
          state_next = hce_pkg::T_COLLECT;
        end
      end
      hce_pkg::T_COLLECT: begin
        // histogram data is registered and arrives in the cycle after its address
        if (s != '0 && hist_data != '0) begin
          node_we = 1'b1;
          node_waddr = n;
          node_wdata = {1'b0, {NODE_W{1'b0}}, hist_data};
          leaf_we = 1'b1;
          n_next = n + NODE_W'(1);
        end
        if (s == CNT_W'(SYMBOLS)) begin
          if (n_next <= NODE_W'(1)) begin
            state_next = hce_pkg::T_DONE;
          end else begin
            j_next = n_next;
            i_next = '0;
            bf_next = 1'b0;
            sf_next = 1'b0;
            state_next = hce_pkg::T_SCAN;
          end
        end else begin
          s_next = s + CNT_W'(1);
        end
      end
      hce_pkg::T_SCAN: begin
        if (i != '0 && !nq_hp) begin
          if (!bf || nq_w < bw) begin
            sf_next = bf;
            sw_next = bw;
            sidx_next = bidx;
            bf_next = 1'b1;
            bw_next = nq_w;
            bidx_next = i_m1;
          end else if (!sf || nq_w < sw) begin
            sf_next = 1'b1;
            sw_next = nq_w;
            sidx_next = i_m1;
          end
        end
        if (i == j) begin
          state_next = hce_pkg::T_LINK_A;
        end else begin
          i_next = i + NODE_W'(1);
        end
      end
      hce_pkg::T_LINK_A: begin
        node_we = 1'b1;
        node_waddr = bidx;
        node_wdata = {1'b1, j, bw};
        state_next = hce_pkg::T_LINK_B;
      end
      hce_pkg::T_LINK_B: begin
        node_we = 1'b1;
        node_waddr = sidx;
        node_wdata = {1'b1, j, sw};
        state_next = hce_pkg::T_LINK_J;
      end
      hce_pkg::T_LINK_J: begin
        node_we = 1'b1;
        node_waddr = j;
        node_wdata = {1'b0, {NODE_W{1'b0}}, bw + sw};
        left_we = 1'b1;
        if (j == root) begin
          code_we = 1'b1;
          code_waddr = j;
          code_wdata = '0;
          i_next = j - NODE_W'(1);
          state_next = hce_pkg::T_WALK_A;
        end else begin
          j_next = j + NODE_W'(1);
          i_next = '0;
          bf_next = 1'b0;
          sf_next = 1'b0;
          state_next = hce_pkg::T_SCAN;
        end
      end
      hce_pkg::T_WALK_A: begin
        state_next = hce_pkg::T_WALK_B;
      end
      hce_pkg::T_WALK_B: begin
        state_next = hce_pkg::T_WALK_C;
      end
      hce_pkg::T_WALK_C: begin
        code_we = 1'b1;
        code_waddr = i;
        code_wdata = {nl, nc};
        if (i < n) begin
          code_wr.en = 1'b1;
          code_wr.sym = 8'(leaf_q);
          code_wr.len = 7'(nl);
          code_wr.bits = 64'(nc);
        end
        if (i == '0) begin
          state_next = hce_pkg::T_DONE;
        end else begin
          i_next = i_m1;
          state_next = hce_pkg::T_WALK_A;
        end
      end
      hce_pkg::T_DONE: begin
        done = 1'b1;
        state_next = hce_pkg::T_IDLE;
      end
      default: begin
        state_next = hce_pkg::T_IDLE;
      end
    endcase
  end
endmodule

// ----- sv/huffman_code_build_and_encode.sv -----
// top level of the byte huffman encoder: command sequencer, code table, bit packer
// depends on hce_pkg, hce_if, hce_hist and hce_tree
//
// one command beat enters on item, results leave on result (valid/ready each)
// count: histogram read, then write back, no result
// encode: a code table load, then one code bit per cycle while no completed byte
//   waits on a full output register, one packed byte per 8 bits, at most 6
//   bytes per beat, last marks the final one; an absent symbol gives nothing
// build: leaf collection over every histogram entry, then for each of the n-1
//   merges a scan over all existing nodes plus the link steps LINK_A, LINK_B
//   and LINK_J, then a code walk through WALK_A, WALK_B and WALK_C per node
// flush and clear: flush gives one result, clear is done while idle
// item.ready is high only while the sequencer is idle; a finished result sits
// in the output register and a command with no result is still taken meanwhile
// a stalled receiver holds the packer at the byte that would complete next
// reset (and the clear command) empties the histogram, the code table and the
// bit buffer at once
module huffman_code_build_and_encode #(
  parameter int SYMBOLS       = 256,
  parameter int COUNT_WIDTH   = 32,
  parameter int MAX_CODE_BITS = 64
) (
  input  logic         clk,
  input  logic         rst,
  hce_item_if.sink     item,
  hce_result_if.source result
);
  localparam int SYM_W = $clog2(SYMBOLS);
  localparam int CNT_W = $clog2(SYMBOLS + 1);
  localparam int LEN_W = $clog2(MAX_CODE_BITS + 1);
  localparam int BIT_W = $clog2(MAX_CODE_BITS);
  localparam int CDW   = LEN_W + MAX_CODE_BITS;
  localparam logic [COUNT_WIDTH-1:0] COUNT_LIMIT =
    COUNT_WIDTH'((64'd1 << (COUNT_WIDTH - 1)) - 64'd10);

  hce_pkg::top_state_t state, state_next;

  logic [COUNT_WIDTH-1:0]   total, total_next;
  logic [SYM_W-1:0]         sym_q, sym_q_next;
  logic [7:0]               bit_buf, bit_buf_next;
  logic [2:0]               fill, fill_next;
  logic [MAX_CODE_BITS-1:0] code_sh, code_sh_next;
  logic [LEN_W-1:0]         rem, rem_next;
  logic [2:0]               nres, nres_next, emit, emit_next;
  logic [CNT_W-1:0]         cnt_q, cnt_q_next;

  logic       ov;
  logic [1:0] o_kind;
  logic [7:0] o_byte;
  logic [2:0] o_pad;
  logic [8:0] o_cnt;
  logic       o_last;

  logic       put, p_last, can_put;
  logic [1:0] p_kind;
  logic [7:0] p_byte;
  logic [2:0] p_pad;
  logic [8:0] p_cnt;

  logic                   accept, sym_ok;
  logic                   hist_clr, hist_we;
  logic [SYM_W-1:0]       hist_raddr;
  logic [COUNT_WIDTH-1:0] hist_rdata;
  logic                   bld_start, bld_done;
  logic [SYM_W-1:0]       bld_haddr;
  logic [CNT_W-1:0]       bld_count;
  hce_pkg::code_wr_t      ct_wr;
  logic                   ct_clr;

  logic [CDW-1:0]     ct_mem [SYMBOLS];
  logic [SYMBOLS-1:0] ct_vld;
  logic [CDW-1:0]     ct_q;
  logic               ct_vq;

  logic [LEN_W-1:0]  ld_len, rem_m1;
  logic [LEN_W:0]    ld_sum;
  logic [LEN_W-3:0]  ld_bytes;
  logic [7:0]        nb;

  assign accept  = item.valid && item.ready;
  assign sym_ok  = {1'b0, item.data_byte} < 9'(SYMBOLS);
  assign can_put = !ov || result.ready;
  assign item.ready = (state == hce_pkg::S_IDLE);

  assign hist_raddr = (state == hce_pkg::S_BUILD) ? bld_haddr : item.data_byte[SYM_W-1:0];

  hce_hist #(.SYMBOLS(SYMBOLS), .COUNT_WIDTH(COUNT_WIDTH)) u_hist (
    .clk     (clk),
    .rst     (rst),
    .clr     (hist_clr),
    .rd_addr (hist_raddr),
    .rd_data (hist_rdata),
    .wr_en   (hist_we),
    .wr_addr (sym_q),
    .wr_data (hist_rdata + COUNT_WIDTH'(1))
  );

  hce_tree #(
    .SYMBOLS(SYMBOLS), .COUNT_WIDTH(COUNT_WIDTH), .MAX_CODE_BITS(MAX_CODE_BITS)
  ) u_tree (
    .clk       (clk),
    .rst       (rst),
    .start     (bld_start),
    .hist_addr (bld_haddr),
    .hist_data (hist_rdata),
    .code_wr   (ct_wr),
    .done      (bld_done),
    .count     (bld_count)
  );

  // code table, read at the incoming byte while idle
  always_ff @(posedge clk) begin
    if (ct_wr.en) begin
      ct_mem[ct_wr.sym[SYM_W-1:0]] <= {ct_wr.len[LEN_W-1:0], ct_wr.bits[MAX_CODE_BITS-1:0]};
    end
    ct_q <= ct_mem[item.data_byte[SYM_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst || ct_clr) begin
      ct_vld <= '0;
      ct_vq  <= 1'b0;
    end else begin
      if (ct_wr.en) begin
        ct_vld[ct_wr.sym[SYM_W-1:0]] <= 1'b1;
      end
      ct_vq <= ct_vld[item.data_byte[SYM_W-1:0]];
    end
  end

  assign ld_len   = ct_vq ? ct_q[CDW-1 -: LEN_W] : '0;
  assign ld_sum   = {1'b0, ld_len} + (LEN_W + 1)'(fill);
  assign ld_bytes = ld_sum[LEN_W:3];
  assign rem_m1   = rem - LEN_W'(1);
  assign nb       = {bit_buf[6:0], code_sh[rem_m1[BIT_W-1:0]]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= hce_pkg::S_IDLE;
      total   <= '0;
      bit_buf <= '0;
      fill    <= '0;
      ov      <= 1'b0;
    end else begin
      state   <= state_next;
      total   <= total_next;
      bit_buf <= bit_buf_next;
      fill    <= fill_next;
      if (put) begin
        ov <= 1'b1;
      end else if (result.ready) begin
        ov <= 1'b0;
      end
    end
    sym_q   <= sym_q_next;
    code_sh <= code_sh_next;
    rem     <= rem_next;
    nres    <= nres_next;
    emit    <= emit_next;
    cnt_q   <= cnt_q_next;
    if (put) begin
      o_kind <= p_kind;
      o_byte <= p_byte;
      o_pad  <= p_pad;
      o_cnt  <= p_cnt;
      o_last <= p_last;
    end
  end

  always_comb begin
    state_next = state;
    total_next = total;
    sym_q_next = sym_q;
    bit_buf_next = bit_buf;
    fill_next = fill;
    code_sh_next = code_sh;
    rem_next = rem;
    nres_next = nres;
    emit_next = emit;
    cnt_q_next = cnt_q;
    hist_clr = 1'b0;
    hist_we = 1'b0;
    bld_start = 1'b0;
    ct_clr = 1'b0;
    put = 1'b0;
    p_kind = hce_pkg::KIND_PACKED;
    p_byte = '0;
    p_pad = '0;
    p_cnt = '0;
    p_last = 1'b1;
    case (state)
      hce_pkg::S_IDLE: begin
        if (accept) begin
          case (item.command)
            hce_pkg::CMD_COUNT: begin
              if (sym_ok && total < COUNT_LIMIT) begin
                sym_q_next = item.data_byte[SYM_W-1:0];
                state_next = hce_pkg::S_COUNT;
              end
            end
            hce_pkg::CMD_BUILD: begin
              bld_start = 1'b1;
              ct_clr = 1'b1;
              state_next = hce_pkg::S_BUILD;
            end
            hce_pkg::CMD_ENCODE: begin
              if (sym_ok) begin
                state_next = hce_pkg::S_ENC_LOAD;
              end
            end
            hce_pkg::CMD_FLUSH: begin
              state_next = hce_pkg::S_FLUSH;
            end
            hce_pkg::CMD_CLEAR: begin
              hist_clr = 1'b1;
              ct_clr = 1'b1;
              total_next = '0;
              bit_buf_next = '0;
              fill_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      hce_pkg::S_COUNT: begin
        hist_we = 1'b1;
        total_next = total + COUNT_WIDTH'(1);
        state_next = hce_pkg::S_IDLE;
      end
      hce_pkg::S_BUILD: begin
        if (bld_done) begin
          cnt_q_next = bld_count;
          state_next = hce_pkg::S_REPORT;
        end
      end
      hce_pkg::S_REPORT: begin
        if (can_put) begin
          put = 1'b1;
          p_kind = hce_pkg::KIND_BUILT;
          p_cnt = 9'(cnt_q);
          state_next = hce_pkg::S_IDLE;
        end
      end
      hce_pkg::S_FLUSH: begin
        if (can_put) begin
          put = 1'b1;
          if (fill != '0) begin
            p_kind = hce_pkg::KIND_FINAL;
            p_pad = 3'(4'd8 - {1'b0, fill});
            p_byte = bit_buf << p_pad;
            bit_buf_next = '0;
            fill_next = '0;
          end else begin
            p_kind = hce_pkg::KIND_EMPTY;
          end
          state_next = hce_pkg::S_IDLE;
        end
      end
      hce_pkg::S_ENC_LOAD: begin
        if (ld_len == '0) begin
          state_next = hce_pkg::S_IDLE;
        end else begin
          code_sh_next = ct_q[MAX_CODE_BITS-1:0];
          rem_next = ld_len;
          emit_next = '0;
          nres_next = (ld_bytes > (LEN_W - 2)'(hce_pkg::MAX_RESULTS)) ?
                      hce_pkg::MAX_RESULTS : 3'(ld_bytes);
          state_next = hce_pkg::S_ENC_SHIFT;
        end
      end
      hce_pkg::S_ENC_SHIFT: begin
        if (fill == 3'd7) begin
          // this bit completes a byte, which needs room in the output register
          if (can_put) begin
            put = 1'b1;
            p_kind = hce_pkg::KIND_PACKED;
            p_byte = nb;
            p_last = (emit + 3'd1 == nres);
            bit_buf_next = '0;
            fill_next = '0;
            rem_next = rem_m1;
            emit_next = emit + 3'd1;
            if (emit + 3'd1 == hce_pkg::MAX_RESULTS || rem_m1 == '0) begin
              state_next = hce_pkg::S_IDLE;
            end
          end
        end else begin
          bit_buf_next = nb;
          fill_next = fill + 3'd1;
          rem_next = rem_m1;
          if (rem_m1 == '0) begin
            state_next = hce_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = hce_pkg::S_IDLE;
      end
    endcase
  end

  assign result.valid        = ov;
  assign result.kind         = o_kind;
  assign result.out_byte     = o_byte;
  assign result.pad_bits     = o_pad;
  assign result.symbol_count = o_cnt;
  assign result.last         = o_last;

  a_hist_wr: assert property (@(posedge clk) disable iff (rst)
    hist_we |-> $past(state) == hce_pkg::S_IDLE || $past(state) == hce_pkg::S_COUNT)
    else $error("histogram written outside a count");

  a_code_wr: assert property (@(posedge clk) disable iff (rst)
    ct_wr.en |-> state == hce_pkg::S_BUILD)
    else $error("code table written outside a build");

  a_bld_done: assert property (@(posedge clk) disable iff (rst)
    bld_done |-> state == hce_pkg::S_BUILD)
    else $error("tree finished while no build was running");

  a_emit_cap: assert property (@(posedge clk) disable iff (rst)
    state == hce_pkg::S_ENC_SHIFT |-> emit < hce_pkg::MAX_RESULTS && rem != '0)
    else $error("packer running past its byte limit or with no bits left");

  a_put_room: assert property (@(posedge clk) disable iff (rst)
    put |-> can_put)
    else $error("result overwritten before it was taken");
endmodule
